// ----- rtl/psbbp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package psbbp_pkg;

  localparam int COUNT_WIDTH = 64;
  localparam int SUM_WIDTH   = COUNT_WIDTH + 2;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  typedef enum logic [1:0] {
    KIND_DOWN  = 2'd0,
    KIND_UP    = 2'd1,
    KIND_LIMIT = 2'd2,
    KIND_TICK  = 2'd3
  } kind_t;

  // classified word passed from front to back
  typedef struct packed {
    kind_t       kind;
    logic        hdr;
    logic        addr_local;
    logic [15:0] len;
    logic [63:0] lim;
  } item_t;

  typedef struct packed {
    logic        verdict;
    logic        addr_local;
    logic [63:0] total_up;
    logic [63:0] total_down;
    logic [63:0] second_number;
    logic [63:0] limit_now;
  } result_t;

  function automatic logic is_local(input logic [31:0] a);
    logic [7:0] o1;
    logic [7:0] o2;
    logic [7:0] o3;
    logic [7:0] o4;
    logic       hit;
    o1  = a[31:24];
    o2  = a[23:16];
    o3  = a[15:8];
    o4  = a[7:0];
    hit = 1'b0;
    case (o1)
      8'd127: hit = 1'b1;
      8'd128: hit = (o2 == 8'd232);
      8'd129: hit = (o2 == 8'd169);
      8'd131: hit = (o2 == 8'd111);
      8'd169: hit = (o2 == 8'd254);
      8'd172: hit = (o2 inside {[8'd16:8'd30]});
      8'd192: begin
        if (o2 == 8'd18)       hit = (o3 == 8'd195);
        else if (o2 == 8'd84)  hit = (o3 == 8'd5);
        else if (o2 == 8'd153) hit = (o3 == 8'd213);
        else                   hit = (o2 == 8'd168);
      end
      8'd193: begin
        if (o2 == 8'd60)      hit = (o3[7:4] == 4'd5);
        else if (o2 == 8'd63) hit = (o3[7:1] == 7'd126);
        else                  hit = 1'b0;
      end
      8'd255: hit = (o2 == 8'd255) && (o3 == 8'd255) && (o4 == 8'd255);
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/psbbp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module psbbp_front (
  input  wire logic               in_push,
  input  wire logic [1:0]         in_kind,
  input  wire logic               in_header_present,
  input  wire logic [31:0]        in_far_address,
  input  wire logic [15:0]        in_packet_length,
  input  wire logic [63:0]        in_limit_value,
  input  wire logic               q_full,
  output logic                    q_wr,
  output psbbp_pkg::item_t        q_item
);

  always_comb begin
    q_wr              = in_push && !q_full;
    q_item.kind       = psbbp_pkg::kind_t'(in_kind);
    q_item.hdr        = in_header_present;
    // lookup only matters for packet words carrying a header
    q_item.addr_local = in_header_present && !in_kind[1] &&
                        psbbp_pkg::is_local(in_far_address);
    q_item.len        = in_packet_length;
    q_item.lim        = in_limit_value;
  end

endmodule

`default_nettype wire

// ----- rtl/psbbp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module psbbp_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr,
  input  wire psbbp_pkg::item_t   wr_item,
  output logic                    full,
  input  wire logic               rd,
  output logic                    rd_valid,
  output psbbp_pkg::item_t        rd_item
);

  psbbp_pkg::item_t mem_r [2];
  logic             wptr_r, wptr_nxt;
  logic             rptr_r, rptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_rd;

  always_comb begin
    full     = (cnt_r == 2'd2);
    rd_valid = (cnt_r != 2'd0);
    rd_item  = mem_r[rptr_r];
    do_rd    = rd && rd_valid;
    wptr_nxt = wptr_r ^ wr;
    rptr_nxt = rptr_r ^ do_rd;
    cnt_nxt  = cnt_r + {1'b0, wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wptr_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/psbbp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module psbbp_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire psbbp_pkg::item_t   q_item,
  output logic                    q_rd,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output psbbp_pkg::result_t      out_res
);

  psbbp_pkg::cnt_t total_up_r, total_up_nxt;
  psbbp_pkg::cnt_t total_down_r, total_down_nxt;
  psbbp_pkg::cnt_t sec_up_r, sec_up_nxt;
  psbbp_pkg::cnt_t sec_down_r, sec_down_nxt;
  psbbp_pkg::cnt_t ticks_r, ticks_nxt;
  logic [63:0]     active_r, active_nxt;
  logic [63:0]     pend_r, pend_nxt;
  logic            pend_vld_r, pend_vld_nxt;

  psbbp_pkg::result_t ob_mem_r [2];
  logic               ob_wptr_r, ob_wptr_nxt;
  logic               ob_rptr_r, ob_rptr_nxt;
  logic [1:0]         ob_cnt_r, ob_cnt_nxt;
  logic               ob_pop;

  logic [psbbp_pkg::SUM_WIDTH-1:0] sum;
  logic                            drop;
  logic                            is_pkt;
  psbbp_pkg::result_t              res;

  always_comb begin
    out_empty = (ob_cnt_r == 2'd0);
    out_res   = ob_mem_r[ob_rptr_r];
    ob_pop    = out_pop && !out_empty;
    // room in the output buffer, counting a slot freed this cycle
    q_rd      = q_valid && ((ob_cnt_r != 2'd2) || ob_pop);

    // exact sum, no wrap: an overflow always exceeds the limit
    sum  = psbbp_pkg::SUM_WIDTH'(sec_up_r) + psbbp_pkg::SUM_WIDTH'(sec_down_r) +
           psbbp_pkg::SUM_WIDTH'(q_item.len);
    drop = (sum > psbbp_pkg::SUM_WIDTH'(active_r));

    is_pkt = (q_item.kind == psbbp_pkg::KIND_DOWN) || (q_item.kind == psbbp_pkg::KIND_UP);

    total_up_nxt   = total_up_r;
    total_down_nxt = total_down_r;
    sec_up_nxt     = sec_up_r;
    sec_down_nxt   = sec_down_r;
    ticks_nxt      = ticks_r;
    active_nxt     = active_r;
    pend_nxt       = pend_r;
    pend_vld_nxt   = pend_vld_r;
    res.verdict    = 1'b0;
    res.addr_local = 1'b0;

    case (q_item.kind)
      psbbp_pkg::KIND_DOWN, psbbp_pkg::KIND_UP: begin
        if (q_item.hdr) begin
          res.addr_local = q_item.addr_local;
          if (!q_item.addr_local) begin
            res.verdict = drop;
            if (q_item.kind == psbbp_pkg::KIND_DOWN) begin
              sec_down_nxt = sec_down_r + psbbp_pkg::COUNT_WIDTH'(q_item.len);
            end else if (!drop) begin
              sec_up_nxt = sec_up_r + psbbp_pkg::COUNT_WIDTH'(q_item.len);
            end
          end
        end
      end
      psbbp_pkg::KIND_LIMIT: begin
        if (!pend_vld_r || (q_item.lim <= pend_r)) begin
          pend_nxt = q_item.lim;
        end
        pend_vld_nxt = 1'b1;
      end
      default: begin
        ticks_nxt      = ticks_r + psbbp_pkg::COUNT_WIDTH'(1);
        active_nxt     = pend_r;
        pend_nxt       = '0;
        pend_vld_nxt   = 1'b0;
        total_up_nxt   = total_up_r + sec_up_r;
        total_down_nxt = total_down_r + sec_down_r;
        sec_up_nxt     = '0;
        sec_down_nxt   = '0;
      end
    endcase

    res.total_up      = 64'(total_up_nxt);
    res.total_down    = 64'(total_down_nxt);
    res.second_number = 64'(ticks_nxt);
    res.limit_now     = active_nxt;

    ob_wptr_nxt = ob_wptr_r ^ q_rd;
    ob_rptr_nxt = ob_rptr_r ^ ob_pop;
    ob_cnt_nxt  = ob_cnt_r + {1'b0, q_rd} - {1'b0, ob_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_up_r   <= '0;
      total_down_r <= '0;
      sec_up_r     <= '0;
      sec_down_r   <= '0;
      ticks_r      <= '0;
      active_r     <= '0;
      pend_r       <= '0;
      pend_vld_r   <= 1'b0;
      ob_wptr_r    <= 1'b0;
      ob_rptr_r    <= 1'b0;
      ob_cnt_r     <= 2'd0;
    end else begin
      if (q_rd) begin
        total_up_r   <= total_up_nxt;
        total_down_r <= total_down_nxt;
        sec_up_r     <= sec_up_nxt;
        sec_down_r   <= sec_down_nxt;
        ticks_r      <= ticks_nxt;
        active_r     <= active_nxt;
        pend_r       <= pend_nxt;
        pend_vld_r   <= pend_vld_nxt;
      end
      ob_wptr_r <= ob_wptr_nxt;
      ob_rptr_r <= ob_rptr_nxt;
      ob_cnt_r  <= ob_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      // verdict only meaningful for packets; res already holds zero otherwise
      ob_mem_r[ob_wptr_r] <= is_pkt ? res : {2'b00, res[255:0]};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/per_second_byte_budget_policer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// in_*      input      in_push / in_full    kind, header_present, far_address,
//                                           packet_length, limit_value
// out_*     output     out_pop / out_empty  verdict, address_local, total_up,
//                                           total_down, second_number, limit_now
//
// One word per cycle sustained while out_pop keeps up. A taken word is written into a
// 2-deep queue; the back reads it from there and registers its result into a 2-deep
// output buffer, whose head drives the out ports until it is popped.
// The back does the budget add and compare combinationally, ahead of that buffer.
// rst_n is synchronous; it zeroes all counters, limits and both queues.
// A stalled output fills the buffer, then the queue, then raises in_full.

module per_second_byte_budget_policer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_kind,
  input  wire logic        in_header_present,
  input  wire logic [31:0] in_far_address,
  input  wire logic [15:0] in_packet_length,
  input  wire logic [63:0] in_limit_value,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic             out_verdict,
  output logic             out_address_local,
  output logic [63:0]      out_total_up,
  output logic [63:0]      out_total_down,
  output logic [63:0]      out_second_number,
  output logic [63:0]      out_limit_now
);

  logic               q_wr;
  logic               q_full;
  logic               q_rd;
  logic               q_valid;
  psbbp_pkg::item_t   q_wr_item;
  psbbp_pkg::item_t   q_rd_item;
  psbbp_pkg::result_t res;

  psbbp_front u_front (
    .in_push           (in_push),
    .in_kind           (in_kind),
    .in_header_present (in_header_present),
    .in_far_address    (in_far_address),
    .in_packet_length  (in_packet_length),
    .in_limit_value    (in_limit_value),
    .q_full            (q_full),
    .q_wr              (q_wr),
    .q_item            (q_wr_item)
  );

  psbbp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (q_wr),
    .wr_item  (q_wr_item),
    .full     (q_full),
    .rd       (q_rd),
    .rd_valid (q_valid),
    .rd_item  (q_rd_item)
  );

  psbbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_rd_item),
    .q_rd      (q_rd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (res)
  );

  always_comb begin
    in_full           = q_full;
    out_verdict       = res.verdict;
    out_address_local = res.addr_local;
    out_total_up      = res.total_up;
    out_total_down    = res.total_down;
    out_second_number = res.second_number;
    out_limit_now     = res.limit_now;
  end

endmodule

`default_nettype wire
